// ----- rtl/shup_pkg.sv -----
// Shared types and constants for the segment height-under-point block.
// No dependencies.
`default_nettype none
package shup_pkg;

	localparam int COORD_W = 20;
	localparam int QUO_W   = 20;
	localparam int CFG_W   = 19;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_SNAP   = 2'd2,
		OP_FLOOR  = 2'd3
	} op_t;

	localparam logic [1:0] REG_SNAP_MARGIN    = 2'd0;
	localparam logic [1:0] REG_FLOOR_MARGIN   = 2'd1;
	localparam logic [1:0] REG_DISTANCE_LIMIT = 2'd2;

	// Tag carried alongside a segment through the arithmetic pipe.
	typedef struct packed {
		logic                       valid;
		logic                       last;
		logic                       use_seg;
		logic                       neg;
		logic signed [COORD_W-1:0]  y1;
	} tag_t;

endpackage
`default_nettype wire

// ----- rtl/shup_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage.
// Depends on shup_pkg (tag_t, QUO_W). Needs num < den * 2**QUO_W.
`default_nettype none
module shup_div
	import shup_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tag_t              in_tag,
	input  wire logic [2*QUO_W-1:0] in_num,
	input  wire logic [QUO_W-1:0]  in_den,
	output tag_t                   out_tag,
	output logic [QUO_W-1:0]       out_quo
);

	tag_t             tag_q [0:QUO_W];
	logic [QUO_W-1:0] rem_q [0:QUO_W];
	logic [QUO_W-1:0] low_q [0:QUO_W];
	logic [QUO_W-1:0] den_q [0:QUO_W];
	logic [QUO_W-1:0] quo_q [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q[0] <= '0;
		end else begin
			tag_q[0] <= in_tag;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= in_num[2*QUO_W-1:QUO_W];
		low_q[0] <= in_num[QUO_W-1:0];
		den_q[0] <= in_den;
		quo_q[0] <= '0;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [QUO_W:0] trial;
		logic [QUO_W:0] diff;
		logic           take;

		always_comb begin
			trial = {rem_q[k], low_q[k][QUO_W-1]};
			diff  = trial - {1'b0, den_q[k]};
			take  = (trial >= {1'b0, den_q[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[k+1] <= '0;
			end else begin
				tag_q[k+1] <= tag_q[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k+1] <= take ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
			low_q[k+1] <= {low_q[k][QUO_W-2:0], 1'b0};
			den_q[k+1] <= den_q[k];
			quo_q[k+1] <= {quo_q[k][QUO_W-2:0], take};
		end
	end

	assign out_tag = tag_q[QUO_W];
	assign out_quo = quo_q[QUO_W];

endmodule
`default_nettype wire

// ----- rtl/segment_height_under_point_core.sv -----
// Segment table with snap and floor queries over line segments in Q16.4.
// Insert, clear and a query on an empty table: result in the cycle after the item is taken.
// Queries: one segment read from the table memory per cycle, then a pipe
// (read, decode, multiply, divider, add) with the compare at its end. Busy holds off
// the next item until the result comes; inserts and clears can follow each other every cycle.
// Reset: table empty, registers at defaults; no clearing pass. No stall.
`default_nettype none
module segment_height_under_point_core
	import shup_pkg::*;
#(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 op,
	input  wire logic signed [COORD_W-1:0]  obj_x,
	input  wire logic signed [COORD_W-1:0]  obj_y,
	input  wire logic [18:0]                obj_height,
	input  wire logic signed [COORD_W-1:0]  obj_bottom,
	input  wire logic signed [COORD_W-1:0]  seg_left_x,
	input  wire logic signed [COORD_W-1:0]  seg_left_y,
	input  wire logic signed [COORD_W-1:0]  seg_right_x,
	input  wire logic signed [COORD_W-1:0]  seg_right_y,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_idx,
	input  wire logic [CFG_W-1:0]           cfg_data,
	output logic                            done,
	output logic                            hit,
	output logic signed [COORD_W-1:0]       line_y,
	output logic                            rejected
);

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

	// Table memory: one row per segment, {left x, left y, right x, right y}.
	logic [4*COORD_W-1:0] seg_mem [0:MAX_SEGMENTS-1];

	// Configuration registers.
	logic [11:0]      snap_margin_q;
	logic [11:0]      floor_margin_q;
	logic [18:0]      distance_limit_q;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    rd_idx_q;
	op_t              qop_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] oy_q;
	logic signed [COORD_W:0]   lo_q;    // snap lower bound on distance
	logic signed [COORD_W:0]   thr_q;   // floor threshold
	logic signed [COORD_W:0]   best_q;  // current snap bound
	logic                      hit_acc_q;
	logic signed [COORD_W-1:0] ly_acc_q;

	logic                 accept;
	logic                 issue;
	logic                 issue_last;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign issue  = (state_q == ST_SCAN);
	assign issue_last = ((CW'(rd_idx_q) + CW'(1)) == count_q);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_margin_q    <= 12'd160;
			floor_margin_q   <= 12'd80;
			distance_limit_q <= 19'd160000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SNAP_MARGIN:    snap_margin_q    <= cfg_data[11:0];
				REG_FLOOR_MARGIN:   floor_margin_q   <= cfg_data[11:0];
				REG_DISTANCE_LIMIT: distance_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- table memory ----------------
	logic [4*COORD_W-1:0] rd_data_s1;
	tag_t                 tag_s1;

	always_ff @(posedge clk) begin
		if (accept && op_t'(op) == OP_INSERT && count_q < CNT_MAX) begin
			seg_mem[count_q[AW-1:0]] <= {seg_left_x, seg_left_y, seg_right_x, seg_right_y};
		end
		rd_data_s1 <= seg_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid   <= issue;
			tag_s1.last    <= issue_last;
			tag_s1.use_seg <= 1'b0;
			tag_s1.neg     <= 1'b0;
			tag_s1.y1      <= '0;
		end
	end

	// ---------------- decode: cover test and differences ----------------
	logic signed [COORD_W-1:0] x1, y1, x2, y2;
	logic signed [COORD_W:0]   dx_w, xoff_w, dy_w;
	logic                      covers;

	always_comb begin
		{x1, y1, x2, y2} = rd_data_s1;
		dx_w   = {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
		xoff_w = {x_q[COORD_W-1], x_q} - {x1[COORD_W-1], x1};
		dy_w   = {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
		// covering and not vertical: x1 <= x <= x2 and x1 < x2
		covers = (x1 <= x_q) && (x_q <= x2) && (x1 < x2);
	end

	tag_t              tag_s2;
	logic [QUO_W-1:0]  dymag_s2, xoff_s2, dx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2.valid   <= tag_s1.valid;
			tag_s2.last    <= tag_s1.last;
			tag_s2.use_seg <= covers;
			tag_s2.neg     <= dy_w[COORD_W];
			tag_s2.y1      <= y1;
		end
	end

	always_ff @(posedge clk) begin
		if (covers) begin
			dymag_s2 <= dy_w[COORD_W] ? QUO_W'(-dy_w) : dy_w[QUO_W-1:0];
			xoff_s2  <= xoff_w[QUO_W-1:0];
			dx_s2    <= dx_w[QUO_W-1:0];
		end else begin
			dymag_s2 <= '0;
			xoff_s2  <= '0;
			dx_s2    <= QUO_W'(1);
		end
	end

	// ---------------- multiply ----------------
	tag_t                tag_s3;
	logic [2*QUO_W-1:0]  prod_s3;
	logic [QUO_W-1:0]    dx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= dymag_s2 * xoff_s2;
		dx_s3   <= dx_s2;
	end

	// ---------------- divide (truncates toward zero on the magnitude) ----------------
	tag_t             div_tag;
	logic [QUO_W-1:0] div_quo;

	shup_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (tag_s3),
		.in_num  (prod_s3),
		.in_den  (dx_s3),
		.out_tag (div_tag),
		.out_quo (div_quo)
	);

	// ---------------- height under the point ----------------
	tag_t                      tag_s4;
	logic signed [COORD_W-1:0] y_s4;
	logic signed [COORD_W:0]   y_sum;

	always_comb begin
		y_sum = div_tag.neg
			? ({div_tag.y1[COORD_W-1], div_tag.y1} - {1'b0, div_quo})
			: ({div_tag.y1[COORD_W-1], div_tag.y1} + {1'b0, div_quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else begin
			tag_s4 <= div_tag;
		end
	end

	always_ff @(posedge clk) begin
		y_s4 <= y_sum[COORD_W-1:0];
	end

	// ---------------- compare and control ----------------
	logic signed [COORD_W:0] y_ext, snap_d;
	logic                    snap_take, floor_take;
	logic signed [COORD_W:0] lo_in, thr_in;

	always_comb begin
		y_ext      = {y_s4[COORD_W-1], y_s4};
		snap_d     = y_ext - {oy_q[COORD_W-1], oy_q};
		snap_take  = tag_s4.valid && tag_s4.use_seg && (snap_d < best_q) && (snap_d >= lo_q);
		floor_take = tag_s4.valid && tag_s4.use_seg && (thr_q <= y_ext);
		lo_in  = $signed({3'b0, obj_height[18:1]}) - $signed({9'b0, snap_margin_q});
		thr_in = {obj_bottom[COORD_W-1], obj_bottom} + {9'b0, floor_margin_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			qop_q     <= OP_SNAP;
			hit_acc_q <= 1'b0;
			done      <= 1'b0;
			hit       <= 1'b0;
			rejected  <= 1'b0;
			line_y    <= '0;
		end else begin
			done     <= 1'b0;
			hit      <= 1'b0;
			rejected <= 1'b0;
			line_y   <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op_t'(op))
							OP_INSERT: begin
								done <= 1'b1;
								if (count_q < CNT_MAX) begin
									count_q <= count_q + CW'(1);
								end else begin
									rejected <= 1'b1;
								end
							end
							OP_CLEAR: begin
								done    <= 1'b1;
								count_q <= '0;
							end
							OP_SNAP, OP_FLOOR: begin
								qop_q     <= op_t'(op);
								hit_acc_q <= 1'b0;
								rd_idx_q  <= '0;
								if (count_q == '0) begin
									done <= 1'b1;   // empty table: miss at once
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + AW'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s4.valid && tag_s4.last) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						if (qop_q == OP_SNAP) begin
							hit    <= hit_acc_q || snap_take;
							line_y <= snap_take ? y_s4
								: (hit_acc_q ? ly_acc_q : '0);
						end else begin
							hit <= hit_acc_q || floor_take;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q != ST_IDLE) begin
				if ((qop_q == OP_SNAP && snap_take) || (qop_q == OP_FLOOR && floor_take)) begin
					hit_acc_q <= 1'b1;
				end
			end
		end
	end

	// Query payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= obj_x;
			oy_q   <= obj_y;
			lo_q   <= lo_in;
			thr_q  <= thr_in;
			best_q <= {2'b0, distance_limit_q};
		end else if (qop_q == OP_SNAP && snap_take) begin
			best_q   <= snap_d;
			ly_acc_q <= y_s4;
		end
	end

endmodule
`default_nettype wire
